// ----- hdl/ria_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ria_pkg: shared types and codes for the rolling ID allocator
// Beat layouts, command codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package ria_pkg;

  // Bitmap word geometry
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_ID_COUNT = 1'b0;
  localparam logic REG_BASE_ID  = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [16:0] id_in;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [16:0] id_out;
    logic        in_use;
    logic        full_res;
    logic [8:0]  used_total;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the accepted beat and read its bitmap word
    logic next_word;  // read the next bitmap word of the allocate scan
    logic commit;     // update state and load the result register
  } ria_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic full;
    logic hit;
  } ria_stat_t;

endpackage

// ----- hdl/ria_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ria_ctrl: sequencer of the rolling ID allocator
// Accepts one beat, steps the bitmap scan and commits into the result register.
// ----------------------------------------------------------------------------
module ria_ctrl
  import ria_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ria_stat_t stat_i,
  output ria_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXAM = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXAM;
        end
      end
      ST_EXAM: begin
        if (stat_i.is_alloc && !stat_i.full && !stat_i.hit) begin
          cmd_o.next_word = 1'b1;
        end else if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/ria_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ria_dpath: bitmap memory and bookkeeping of the rolling ID allocator
// Word-wide bitmap with per-word valid bits, cursor, busy count, result register.
// ----------------------------------------------------------------------------
module ria_dpath
  import ria_pkg::*;
#(
  parameter int unsigned MAX_IDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ria_cmd_t    cmd_i,
  output ria_stat_t   stat_o,
  input  in_beat_t    in_data_i,
  input  logic        cfg_clear_i,
  input  logic [8:0]  n_i,
  input  logic [15:0] base_i,
  output out_beat_t   out_data_o
);

  localparam int unsigned NumWords = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned WordIdxW = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic [WORD_W-1:0]   mem_q [NumWords];
  logic [NumWords-1:0] row_valid_q, row_valid_d;
  logic [WORD_W-1:0]   rd_data_q;
  logic                rd_valid_q;
  logic [WordIdxW-1:0] wp_q, rd_addr, wp_next, ld_word, last_word;
  logic                first_q;
  logic [1:0]          cmd_q;
  logic [8:0]          slot_q;
  logic                oor_q;
  logic [8:0]          cursor_q, cursor_d;
  logic [8:0]          busy_q, busy_d;
  out_beat_t           out_q, out_d;

  logic [17:0]         diff;
  logic                ld_oor;
  logic [8:0]          cur_eff, ld_slot, nm1, hit_slot, slot_p1;
  logic [WORD_W-1:0]   word, low_mask, high_mask, free_vec, wr_word;
  logic [BIT_W-1:0]    bit_sel, hit_bit;
  logic                wr_en, rd_en;

  // Accept side: map the identifier to a slot and pick the first word to read
  assign diff    = {1'b0, in_data_i.id_in} - {2'b00, base_i};
  assign ld_oor  = diff[17] || (diff[16:0] >= {8'd0, n_i});
  assign cur_eff = (cursor_q >= n_i) ? 9'd0 : cursor_q;
  assign ld_slot = (in_data_i.cmd == CMD_ALLOC) ? cur_eff : diff[8:0];
  assign ld_word = (in_data_i.cmd != CMD_ALLOC && ld_oor) ? '0 :
                   WordIdxW'(ld_slot >> BIT_W);

  // Scan side
  assign nm1       = n_i - 9'd1;
  assign last_word = WordIdxW'(nm1 >> BIT_W);
  assign wp_next   = (wp_q == last_word) ? '0 : wp_q + 1'b1;
  assign rd_en     = cmd_i.load || cmd_i.next_word;
  assign rd_addr   = cmd_i.load ? ld_word : wp_next;

  assign word      = rd_valid_q ? rd_data_q : '0;
  assign bit_sel   = slot_q[BIT_W-1:0];
  assign low_mask  = first_q ? ~({WORD_W{1'b1}} << bit_sel) : '0;
  assign high_mask = (wp_q == last_word) ?
                     ({{(WORD_W-1){1'b1}}, 1'b0} << nm1[BIT_W-1:0]) : '0;
  assign free_vec  = ~word & ~low_mask & ~high_mask;

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) hit_bit = BIT_W'(i);
    end
  end

  assign hit_slot = 9'({wp_q, hit_bit});
  assign slot_p1  = hit_slot + 9'd1;

  assign stat_o.is_alloc = (cmd_q == CMD_ALLOC);
  assign stat_o.full     = (busy_q >= n_i);
  assign stat_o.hit      = |free_vec;

  always_comb begin
    row_valid_d = row_valid_q;
    cursor_d    = cursor_q;
    busy_d      = busy_q;
    wr_en       = 1'b0;
    wr_word     = word;
    out_d       = '0;
    if (cmd_i.commit) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (stat_o.full) begin
            out_d.status = 1'b1;
          end else begin
            wr_en        = 1'b1;
            wr_word      = word | ({{(WORD_W-1){1'b0}}, 1'b1} << hit_bit);
            busy_d       = busy_q + 9'd1;
            cursor_d     = (slot_p1 >= n_i) ? 9'd0 : slot_p1;
            out_d.id_out = {1'b0, base_i} + {8'd0, hit_slot};
          end
        end
        CMD_FREE: begin
          if (oor_q || !word[bit_sel]) begin
            out_d.status = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_word = word & ~({{(WORD_W-1){1'b0}}, 1'b1} << bit_sel);
            busy_d  = busy_q - 9'd1;
          end
        end
        CMD_QUERY: begin
          out_d.in_use = oor_q || word[bit_sel];
        end
        CMD_CLEAR: begin
          row_valid_d = '0;
          busy_d      = '0;
        end
        default: begin
          out_d.status = 1'b1;
        end
      endcase
      if (wr_en) begin
        row_valid_d[wp_q] = 1'b1;
      end
      out_d.full_res   = (busy_d == n_i);
      out_d.used_total = busy_d;
    end
    if (cfg_clear_i) begin
      row_valid_d = '0;
      busy_d      = '0;
      cursor_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      cursor_q    <= '0;
      busy_q      <= '0;
    end else begin
      row_valid_q <= row_valid_d;
      cursor_q    <= cursor_d;
      busy_q      <= busy_d;
    end
  end

  // Bitmap memory: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q  <= mem_q[rd_addr];
      rd_valid_q <= row_valid_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wp_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_data_i.cmd;
      slot_q  <= ld_slot;
      oor_q   <= ld_oor;
      wp_q    <= ld_word;
      first_q <= 1'b1;
    end else if (cmd_i.next_word) begin
      wp_q    <= wp_next;
      first_q <= 1'b0;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hdl/rolling_id_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_id_allocator: next-fit identifier allocator over a bitmap
// Top level: APB registers, sequencer and bitmap datapath.
// ----------------------------------------------------------------------------
// The block hands out identifiers (slot index plus base_id) next-fit from a
// rolling cursor, frees and queries them, and clears the whole pool, one beat
// at a time with one result beat per command. The bitmap lives in a memory of
// 32-bit words read one word per cycle, so free, query, clear all and an
// allocate on a full pool read a single word before the result, while an
// allocate reads one further word for each word it must look past. A new beat
// is taken once the previous one has been committed to the result register,
// even while that result still waits on out_ready_i. Every word carries a
// valid bit, so reset, a clear all and a write of id_count empty the pool at
// once with no sweep. Write the registers only while the block is idle: a
// write of id_count also empties the pool and sets the cursor back to slot 0.
// ----------------------------------------------------------------------------
module rolling_id_allocator
  import ria_pkg::*;
#(
  parameter int unsigned MAX_IDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Largest effective pool: bounded by the bitmap and by the 9-bit id_count
  localparam int unsigned CapIds = (MAX_IDS > 511) ? 511 : MAX_IDS;

  logic [8:0]  id_count_q;
  logic [15:0] base_id_q;
  logic        cfg_wr;
  logic        reg_idx;
  logic        cfg_clear;
  logic [8:0]  n_eff;
  ria_cmd_t    ctrl_cmd;
  ria_stat_t   dp_stat;

  // APB: no wait states, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_BASE_ID) ? {16'd0, base_id_q} : {23'd0, id_count_q};

  // A write of id_count reinitializes the pool
  assign cfg_clear = cfg_wr && (reg_idx == REG_ID_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_count_q <= 9'd256;
      base_id_q  <= '0;
    end else if (cfg_wr) begin
      if (reg_idx == REG_ID_COUNT) begin
        id_count_q <= pwdata[8:0];
      end else begin
        base_id_q <= pwdata[15:0];
      end
    end
  end

  // Effective pool size: zero acts as one, clip at the bitmap depth
  assign n_eff = (id_count_q == '0)          ? 9'd1 :
                 (id_count_q > 9'(CapIds))   ? 9'(CapIds) : id_count_q;

  ria_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  ria_dpath #(
    .MAX_IDS (MAX_IDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (in_data_i),
    .cfg_clear_i (cfg_clear),
    .n_i         (n_eff),
    .base_i      (base_id_q),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // One beat in flight: an accept is followed by a busy cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("beat accepted while previous one still in work");

  // A commit always shows up as a pending result
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  // Load and commit never coincide
  a_load_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.load |-> !ctrl_cmd.commit && !ctrl_cmd.next_word)
    else $error("load overlaps scan or commit");

  // Reported use never exceeds the pool size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.used_total <= n_eff))
    else $error("used count above pool size");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for rolling_id_allocator
// Drives command beats through the valid/ready channel and programs id_count
// and base_id over APB between phases. An in-bench model of the next-fit pool
// predicts every result beat, and a monitor checks each one field by field.
// ----------------------------------------------------------------------------
module tb;
  import ria_pkg::*;

  localparam int unsigned POOL_DEPTH  = 256;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  // Clock, reset and all block inputs start at known values
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_beat_t    in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  out_beat_t   out_data_o;
  logic [31:0] prdata;
  logic        pready;

  // Pool model: in-use marks, next-fit cursor, in-use count and registers
  logic        pool_taken [POOL_DEPTH];
  int unsigned pool_cursor;
  int unsigned pool_used;
  logic [8:0]  cfg_id_count;
  logic [15:0] cfg_base;

  // Predicted result beats, oldest first
  out_beat_t   pending_results[$];
  out_beat_t   oldest_result;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt;
  int unsigned stall_left = 0;
  // Enables random bubbles on the command side and stalls on the result side
  logic        bubbles_on = 1'b1;

  rolling_id_allocator #(
    .MAX_IDS(POOL_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake or a lost result beat ends here
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("rolling_id_allocator regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pool model
  // --------------------------------------------------------------------------

  // id_count of zero behaves as one slot, anything past the depth as the depth
  function automatic int unsigned pool_size();
    if (cfg_id_count == 0) return 1;
    if (cfg_id_count > POOL_DEPTH) return POOL_DEPTH;
    return cfg_id_count;
  endfunction

  function automatic void empty_pool();
    for (int unsigned s = 0; s < POOL_DEPTH; s++) pool_taken[s] = 1'b0;
    pool_used = 0;
  endfunction

  // Apply one command to the pool model and return the beat it must produce
  function automatic out_beat_t allocator_result(input in_beat_t beat);
    out_beat_t   res;
    int unsigned n;
    int unsigned slot;
    int unsigned k;
    logic        in_range;
    res      = '0;
    n        = pool_size();
    in_range = (beat.id_in >= cfg_base) && (beat.id_in - cfg_base < n);
    slot     = beat.id_in - cfg_base;
    case (beat.cmd)
      CMD_ALLOC: begin
        if (pool_used >= n) begin
          res.status = 1'b1;
        end else begin
          // Scan next-fit from the cursor, wrapping at the pool size
          slot = (pool_cursor >= n) ? 0 : pool_cursor;
          for (k = 0; k < n && pool_taken[slot]; k++) slot = (slot + 1 >= n) ? 0 : slot + 1;
          pool_taken[slot] = 1'b1;
          pool_used++;
          pool_cursor = (slot + 1 >= n) ? 0 : slot + 1;
          res.id_out  = 17'(slot + cfg_base);
        end
      end
      CMD_FREE: begin
        if (!in_range || !pool_taken[slot]) begin
          res.status = 1'b1;
        end else begin
          pool_taken[slot] = 1'b0;
          pool_used--;
        end
      end
      CMD_QUERY: begin
        res.in_use = !in_range || pool_taken[slot];
      end
      default: begin
        // Clear all keeps the cursor where it is
        empty_pool();
      end
    endcase
    res.full_res   = (pool_used == n);
    res.used_total = 9'(pool_used);
    return res;
  endfunction

  // Pick an identifier for free or query: mostly live slots, some bounds,
  // some fully random values
  function automatic logic [16:0] pick_id();
    int unsigned n;
    int unsigned slot;
    n = pool_size();
    case ($urandom_range(0, 9))
      6: return 17'(cfg_base - 1);
      7: return 17'(cfg_base + n);
      8, 9: return 17'($urandom);
      default: begin
        slot = $urandom_range(0, n - 1);
        for (int t = 0; t < 8 && !pool_taken[slot]; t++) slot = $urandom_range(0, n - 1);
        return 17'(cfg_base + slot);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // --------------------------------------------------------------------------

  // Stall in bursts of random length while bubbles are enabled
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (bubbles_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare every accepted result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data_o.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.id_out !== oldest_result.id_out) begin
          $error("id_out: expected 0x%0h, got 0x%0h", oldest_result.id_out, out_data_o.id_out);
          mismatches++;
        end
        if (out_data_o.in_use !== oldest_result.in_use) begin
          $error("in_use: expected %0d, got %0d", oldest_result.in_use, out_data_o.in_use);
          mismatches++;
        end
        if (out_data_o.full_res !== oldest_result.full_res) begin
          $error("full_res: expected %0d, got %0d",
                 oldest_result.full_res, out_data_o.full_res);
          mismatches++;
        end
        if (out_data_o.used_total !== oldest_result.used_total) begin
          $error("used_total: expected %0d, got %0d",
                 oldest_result.used_total, out_data_o.used_total);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Send one command beat. Valid is left high on return so a back-to-back
  // beat follows without a bubble; callers that stop sending call drain_pool.
  task automatic send_cmd(input logic [1:0] cmd, input logic [16:0] id);
    in_beat_t beat;
    beat.cmd   = cmd;
    beat.id_in = id;
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(allocator_result(beat));
  endtask

  // Drop valid and hold until every predicted result beat has been seen
  task automatic drain_pool();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_ID_COUNT) begin
      // A size write reinitializes the whole pool, cursor included
      cfg_id_count = value[8:0];
      empty_pool();
      pool_cursor = 0;
    end else begin
      cfg_base = value[15:0];
    end
    @(posedge clk_i);
  endtask

  // Random traffic: allocate-heavy so pools fill and wrap, frees aimed at
  // live slots, queries, and a rare clear all. Pause once halfway through.
  task automatic run_mix(input int unsigned beats);
    int unsigned pick;
    for (int unsigned b = 0; b < beats; b++) begin
      if (b == beats / 2) drain_pool();
      pick = $urandom_range(0, 99);
      if (pick < 45)      send_cmd(CMD_ALLOC, 17'($urandom));
      else if (pick < 72) send_cmd(CMD_FREE, pick_id());
      else if (pick < 97) send_cmd(CMD_QUERY, pick_id());
      else                send_cmd(CMD_CLEAR, 17'($urandom));
    end
    drain_pool();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: 256 slots at base 0
  task automatic test_reset_pool();
    send_cmd(CMD_QUERY, 17'd0);
    send_cmd(CMD_QUERY, 17'h1FFFF);   // out of range reports in use
    send_cmd(CMD_FREE,  17'd5);       // slot never taken
    send_cmd(CMD_FREE,  17'h1FFFF);   // out of range
    send_cmd(CMD_ALLOC, 17'd0);
    send_cmd(CMD_ALLOC, 17'h1FFFF);
    send_cmd(CMD_ALLOC, 17'd0);
    send_cmd(CMD_QUERY, 17'd1);
    send_cmd(CMD_FREE,  17'd1);
    send_cmd(CMD_ALLOC, 17'd0);       // next-fit skips the hole at slot 1
    send_cmd(CMD_CLEAR, 17'd0);
    send_cmd(CMD_QUERY, 17'd0);
    send_cmd(CMD_ALLOC, 17'd0);       // cursor survives clear all
    drain_pool();
  endtask

  // Four slots at the top base: ids carry into bit 16, pool fills and wraps
  task automatic test_small_pool_bounds();
    write_reg(REG_ID_COUNT, 32'd4);
    write_reg(REG_BASE_ID, 32'h0000_FFFF);
    repeat (4) send_cmd(CMD_ALLOC, 17'd0);
    send_cmd(CMD_ALLOC, 17'd0);       // full
    send_cmd(CMD_FREE,  17'h0FFFE);   // just below base
    send_cmd(CMD_FREE,  17'h10003);   // just past the end
    send_cmd(CMD_FREE,  17'h10001);
    send_cmd(CMD_FREE,  17'h10001);   // already free
    send_cmd(CMD_ALLOC, 17'd0);       // wraps back to the freed slot
    send_cmd(CMD_QUERY, 17'h1FFFF);
    send_cmd(CMD_QUERY, 17'h10000);
    drain_pool();
  endtask

  // Largest pool: fill every slot, overflow once, punch holes and refill
  task automatic test_full_pool();
    write_reg(REG_ID_COUNT, 32'd256);
    write_reg(REG_BASE_ID, 32'($urandom_range(0, 65535)));
    repeat (257) send_cmd(CMD_ALLOC, 17'($urandom));
    repeat (3) send_cmd(CMD_FREE, 17'(cfg_base + $urandom_range(0, 255)));
    repeat (3) send_cmd(CMD_ALLOC, 17'($urandom));
    drain_pool();
  endtask

  // Sweep sizes across word boundaries and the out-of-range encodings
  task automatic test_size_sweep();
    int unsigned sizes[9] = '{1, 0, 2, 31, 32, 33, 511, 0, 8};
    int unsigned beats[9] = '{60, 60, 80, 110, 110, 110, 140, 120, 100};
    sizes[7] = $urandom_range(1, 256);
    for (int k = 0; k < 9; k++) begin
      write_reg(REG_ID_COUNT, sizes[k]);
      if (k == 0)      write_reg(REG_BASE_ID, 32'd0);
      else if (k == 1) write_reg(REG_BASE_ID, 32'h0000_FFFF);
      else             write_reg(REG_BASE_ID, 32'($urandom_range(0, 65535)));
      run_mix(beats[k]);
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate_tail();
    bubbles_on = 1'b0;
    write_reg(REG_ID_COUNT, 32'd16);
    write_reg(REG_BASE_ID, 32'($urandom_range(0, 65535)));
    run_mix(120);
  endtask

  initial begin
    cfg_id_count = 9'd256;
    cfg_base     = 16'd0;
    pool_cursor  = 0;
    empty_pool();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pool();
    test_small_pool_bounds();
    test_full_pool();
    test_size_sweep();
    test_full_rate_tail();

    drain_pool();
    // Let any stray beat surface before judging
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("rolling_id_allocator regression: pass");
    end else begin
      $display("rolling_id_allocator regression: fail");
    end
    $finish;
  end

endmodule
